// ----- hw/rtl/crc_packet_deframer_macros.svh -----
// assertion macros shared by the deframer rtl
// no dependencies; taken in by `include where checks are written
`ifndef CRC_PACKET_DEFRAMER_MACROS_SVH
`define CRC_PACKET_DEFRAMER_MACROS_SVH
`ifndef ASSERT_OFF
// condition a implies condition b in the same cycle
`define CPD_ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed: implication");
// condition a implies condition b in the next cycle
`define CPD_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");
`else
`define CPD_ASSERT_IMPLIES(label, clk, rst, a, b)
`define CPD_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ----- hw/rtl/crcpd_pkg.sv -----
// shared types, constants and functions of the packet deframer
// no dependencies; used by every rtl module of the block
`timescale 1ns / 1ps

package crcpd_pkg;

  localparam int unsigned MAX_ENTRIES = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [6:0]  MIN_LENGTH = 7'd3;
  localparam logic [6:0]  RESET_LENGTH = 7'd30;

  // register indexes on the configuration port
  localparam logic [2:0] CFG_DEFAULT_LENGTH = 3'd0;
  localparam logic [2:0] CFG_TYPE_BASE      = 3'd1;
  localparam logic [2:0] CFG_LENGTH_BASE    = 3'd2;

  // what a word does in the back end
  typedef enum logic [1:0] {
    ROLE_COVER,
    ROLE_LOW,
    ROLE_LAST
  } role_t;

  typedef struct packed {
    logic [7:0]         data;
    logic [6:0]         idx;
    logic [6:0]         len;
    logic signed [15:0] strength;
    role_t              role;
    logic               start;
  } entry_t;

  function automatic logic [6:0] clamp_length(input logic [6:0] len);
    return (len < MIN_LENGTH) ? MIN_LENGTH : len;
  endfunction

  // eight msb-first steps of crc-16, poly 0x1021
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/crcpd_front.sv -----
// front end: packet tracking, type lookup and word classification
// depends on crcpd_pkg
`timescale 1ns / 1ps

module crcpd_front #(
  parameter int unsigned TABLE_ENTRIES = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rx_valid,
  output logic                rx_stall,
  input  logic [7:0]          rx_byte,
  input  logic                rx_error,
  input  logic signed [15:0]  rx_strength,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                q_full,
  output logic                q_push,
  output crcpd_pkg::entry_t   q_entry
);

  logic [6:0] default_length;
  logic [7:0] tbl_type   [TABLE_ENTRIES];
  logic [6:0] tbl_length [TABLE_ENTRIES];

  logic               receiving;
  logic [6:0]         byte_count;
  logic [6:0]         current_length;
  logic signed [15:0] first_strength;

  logic               accept;
  logic               start;
  logic [6:0]         idx;
  logic [6:0]         base_len;
  logic [6:0]         len;
  logic [7:0]         pos_end;
  logic signed [15:0] strength;
  crcpd_pkg::role_t   role;

  assign cfg_ready = 1'b1;
  assign rx_stall  = q_full;
  assign accept    = rx_valid && !rx_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      default_length <= crcpd_pkg::RESET_LENGTH;
      for (int e = 0; e < TABLE_ENTRIES; e++) begin
        tbl_type[e]   <= 8'h00;
        tbl_length[e] <= crcpd_pkg::RESET_LENGTH;
      end
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == crcpd_pkg::CFG_DEFAULT_LENGTH) begin
        default_length <= cfg_data[6:0];
      end
      for (int e = 0; e < TABLE_ENTRIES; e++) begin
        if (cfg_index == crcpd_pkg::CFG_TYPE_BASE + 3'(2 * e)) begin
          tbl_type[e] <= cfg_data;
        end
        if (cfg_index == crcpd_pkg::CFG_LENGTH_BASE + 3'(2 * e)) begin
          tbl_length[e] <= cfg_data[6:0];
        end
      end
    end
  end

  // classify the incoming word
  always_comb begin
    start    = !receiving;
    idx      = start ? 7'd0 : byte_count;
    base_len = start ? crcpd_pkg::clamp_length(default_length) : current_length;
    strength = start ? rx_strength : first_strength;
    len      = base_len;
    if (idx == 7'd1) begin
      // last matching entry wins
      for (int e = 0; e < TABLE_ENTRIES; e++) begin
        if (tbl_type[e] == rx_byte) begin
          len = crcpd_pkg::clamp_length(tbl_length[e]);
        end
      end
    end
    pos_end = {1'b0, idx} + 8'd2;
    if (pos_end < {1'b0, len}) begin
      role = crcpd_pkg::ROLE_COVER;
    end else if (pos_end == {1'b0, len}) begin
      role = crcpd_pkg::ROLE_LOW;
    end else begin
      role = crcpd_pkg::ROLE_LAST;
    end
  end

  always_comb begin
    q_push           = accept && !rx_error;
    q_entry.data     = rx_byte;
    q_entry.idx      = idx;
    q_entry.len      = len;
    q_entry.strength = strength;
    q_entry.role     = role;
    q_entry.start    = start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receiving      <= 1'b0;
      byte_count     <= 7'd0;
      current_length <= crcpd_pkg::RESET_LENGTH;
      first_strength <= 16'sd0;
    end else if (accept) begin
      if (rx_error) begin
        receiving  <= 1'b0;
        byte_count <= 7'd0;
      end else begin
        current_length <= len;
        first_strength <= strength;
        if (role == crcpd_pkg::ROLE_LAST) begin
          receiving  <= 1'b0;
          byte_count <= 7'd0;
        end else begin
          receiving  <= 1'b1;
          byte_count <= idx + 7'd1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/crcpd_queue.sv -----
// short fifo of classified words between front and back end
// depends on crcpd_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "crc_packet_deframer_macros.svh"

module crcpd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  crcpd_pkg::entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              pop_valid,
  output crcpd_pkg::entry_t pop_entry
);

  localparam int unsigned PTR_W = (crcpd_pkg::QUEUE_DEPTH > 1) ?
                                  $clog2(crcpd_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(crcpd_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(crcpd_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(crcpd_pkg::QUEUE_DEPTH);

  crcpd_pkg::entry_t slots [crcpd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full      = (count == FULL_CNT);
  assign pop_valid = (count != '0);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `CPD_ASSERT_IMPLIES(a_no_overflow, clk, rst, push, (!full))
  `CPD_ASSERT_IMPLIES(a_no_underflow, clk, rst, pop, pop_valid)

endmodule

// ----- hw/rtl/crcpd_back.sv -----
// back end: running crc, received crc check and output register
// depends on crcpd_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "crc_packet_deframer_macros.svh"

module crcpd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  crcpd_pkg::entry_t  q_entry,
  output logic               q_pop,
  output logic               pkt_valid,
  input  logic               pkt_stall,
  output logic [7:0]         out_byte,
  output logic [6:0]         byte_index,
  output logic               is_last,
  output logic               crc_ok,
  output logic [15:0]        crc_computed,
  output logic signed [15:0] packet_strength,
  output logic [6:0]         packet_length
);

  logic [15:0] running_crc;
  logic [7:0]  crc_low_byte;
  logic [15:0] crc_base;
  logic [15:0] received;

  assign q_pop    = q_valid && (!pkt_valid || !pkt_stall);
  assign crc_base = q_entry.start ? 16'h0000 : running_crc;
  assign received = {q_entry.data, crc_low_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc  <= 16'h0000;
      crc_low_byte <= 8'h00;
    end else if (q_pop) begin
      case (q_entry.role)
        crcpd_pkg::ROLE_COVER: begin
          running_crc <= crcpd_pkg::crc_update(crc_base, q_entry.data);
        end
        crcpd_pkg::ROLE_LOW: begin
          crc_low_byte <= q_entry.data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_valid <= 1'b0;
    end else if (q_pop) begin
      pkt_valid <= 1'b1;
    end else if (!pkt_stall) begin
      pkt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_byte        <= q_entry.data;
      byte_index      <= q_entry.idx;
      packet_strength <= q_entry.strength;
      packet_length   <= q_entry.len;
      if (q_entry.role == crcpd_pkg::ROLE_LAST) begin
        is_last      <= 1'b1;
        crc_ok       <= (received == running_crc);
        crc_computed <= running_crc;
      end else begin
        is_last      <= 1'b0;
        crc_ok       <= 1'b0;
        crc_computed <= 16'h0000;
      end
    end
  end

  // a packet always opens on a covered word
  `CPD_ASSERT_IMPLIES(a_start_is_cover, clk, rst, (q_pop && q_entry.start), (q_entry.role == crcpd_pkg::ROLE_COVER))
  // the last word sits at the end of its packet
  `CPD_ASSERT_IMPLIES(a_last_at_end, clk, rst, (pkt_valid && is_last), ((8'(byte_index) + 8'd1) == 8'(packet_length)))

endmodule

// ----- hw/rtl/crc_packet_deframer.sv -----
// top level of the crc-16 packet deframer
// depends on crcpd_pkg, crcpd_front, crcpd_queue and crcpd_back
`timescale 1ns / 1ps
//
//  channel   handshake              payload
//  -------   ---------------------  -----------------------------------------
//  rx        rx_valid / rx_stall    rx_byte, rx_error, rx_strength
//  pkt       pkt_valid / pkt_stall  out_byte, byte_index, is_last, crc_ok,
//                                   crc_computed, packet_strength, packet_length
//  cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  one word a cycle sustained while pkt_stall is low; a good word is classified and
//  written into the queue at its rx edge and reaches pkt through the queue slot,
//  then the back end's output register. the crc update of eight bits is one
//  combinational step in the back end, which sets the clock-to-clock path.
//  rst is synchronous: packet state idle, crc cleared, configuration registers to reset values.
//  rx_stall rises only while the two-word queue is full; cfg_ready is always high.
//  error words are absorbed in the front end and never reach the queue.

module crc_packet_deframer #(
  parameter int unsigned TABLE_ENTRIES = 3
) (
  input  logic               clk,
  input  logic               rst,
  // received words
  input  logic               rx_valid,
  output logic               rx_stall,
  input  logic [7:0]         rx_byte,
  input  logic               rx_error,
  input  logic signed [15:0] rx_strength,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  // framed words out
  output logic               pkt_valid,
  input  logic               pkt_stall,
  output logic [7:0]         out_byte,
  output logic [6:0]         byte_index,
  output logic               is_last,
  output logic               crc_ok,
  output logic [15:0]        crc_computed,
  output logic signed [15:0] packet_strength,
  output logic [6:0]         packet_length
);

  // front to queue
  logic              q_push;
  logic              q_full;
  crcpd_pkg::entry_t q_push_entry;

  // queue to back
  logic              q_pop;
  logic              q_valid;
  crcpd_pkg::entry_t q_pop_entry;

  // front end: tracks packet position, looks up the length from the type word,
  // decides whether each word is covered by the crc, the low crc byte or the last
  crcpd_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .rx_valid    (rx_valid),
    .rx_stall    (rx_stall),
    .rx_byte     (rx_byte),
    .rx_error    (rx_error),
    .rx_strength (rx_strength),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_push_entry)
  );

  // decoupling queue, so a stalled output does not stop the front at once
  crcpd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (q_pop_entry)
  );

  // back end: running crc, received crc assembly, output register
  crcpd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_entry         (q_pop_entry),
    .q_pop           (q_pop),
    .pkt_valid       (pkt_valid),
    .pkt_stall       (pkt_stall),
    .out_byte        (out_byte),
    .byte_index      (byte_index),
    .is_last         (is_last),
    .crc_ok          (crc_ok),
    .crc_computed    (crc_computed),
    .packet_strength (packet_strength),
    .packet_length   (packet_length)
  );

endmodule
